FILE: src/pcp_pkg.sv
// Shared constants, register codes and types of the pitch cascade PID block.
package pcp_pkg;

   localparam int FRAC_BITS = 16;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int STICK_W  = 11;
   localparam int ROLL_W   = 25;
   localparam int RATE_W   = 24;
   localparam int TORQUE_W = 20;
   localparam int WORD_W   = 32;
   localparam int SINT_W   = 48;
   localparam int GAIN_W   = 24;
   localparam int LIMIT_W  = 29;
   localparam int AINT_W   = FRAC_BITS + 2;
   localparam int SUM_W    = SINT_W + 2;

   // Stream packing
   localparam int ROLL_LSB    = STICK_W;
   localparam int RATE_LSB    = STICK_W + ROLL_W;
   localparam int REQ_TDATA_W = ((STICK_W + ROLL_W + RATE_W + 7) / 8) * 8;
   localparam int RSP_BITS    = TORQUE_W + 2 * WORD_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   // Shared multiplier
   localparam int MUL_A_W = WORD_W + 1;
   localparam int MUL_B_W = (FRAC_BITS + 9 > GAIN_W + 1) ? FRAC_BITS + 9 : GAIN_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int RND_W   = MUL_P_W - FRAC_BITS;

   // Scale factors in Q.F
   localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
   localparam longint SCALE_K   = ((longint'(1024) << FRAC_BITS) + 22) / 45;
   localparam longint STICK_K   = ((longint'(3) << FRAC_BITS) + 500) / 1000;
   localparam int     DIV_SHIFT = FRAC_BITS + 10;
   localparam longint DIV5_K    = ((longint'(1) << DIV_SHIFT) + 4) / 5;
   localparam int     DIV_BIAS_SHIFT = FRAC_BITS + 3;

   // Modes
   localparam logic [CMD_W-1:0] CMD_REMOTE = 2'd0;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;
   localparam logic [REG_IDX_W-1:0] REG_ANGLE_KP    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ANGLE_KI    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ANGLE_KD    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_KP    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_KI    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_KD    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_PITCH_UPPER = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_PITCH_LOWER = 3'd7;

   typedef struct packed {
      logic [GAIN_W-1:0]  angle_kp;
      logic [GAIN_W-1:0]  angle_ki;
      logic [GAIN_W-1:0]  angle_kd;
      logic [GAIN_W-1:0]  speed_kp;
      logic [GAIN_W-1:0]  speed_ki;
      logic [GAIN_W-1:0]  speed_kd;
      logic [LIMIT_W-1:0] pitch_upper;
      logic [LIMIT_W-1:0] pitch_lower;
   } pcp_cfg_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } pcp_mul_req_type;

endpackage

FILE: src/pcp_mul.sv
// Shared signed multiplier with a registered product.
module pcp_mul (
   input  logic                                  clock,
   input  pcp_pkg::pcp_mul_req_type              req,
   output logic signed [pcp_pkg::MUL_P_W-1:0]    prod_ff
);

   logic signed [pcp_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = $signed(req.a) * $signed(req.b);

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

FILE: src/pcp_csr.sv
// Configuration registers of the pitch cascade PID behind an APB-style port.
module pcp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pcp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pcp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pcp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output pcp_pkg::pcp_cfg_type              cfg
);

   pcp_pkg::pcp_cfg_type              cfg_ff;
   logic                              wr_en;
   logic [pcp_pkg::REG_IDX_W-1:0]     idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[pcp_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (idx)
            pcp_pkg::REG_ANGLE_KP:    cfg_ff.angle_kp    <= csr_pwdata[pcp_pkg::GAIN_W-1:0];
            pcp_pkg::REG_ANGLE_KI:    cfg_ff.angle_ki    <= csr_pwdata[pcp_pkg::GAIN_W-1:0];
            pcp_pkg::REG_ANGLE_KD:    cfg_ff.angle_kd    <= csr_pwdata[pcp_pkg::GAIN_W-1:0];
            pcp_pkg::REG_SPEED_KP:    cfg_ff.speed_kp    <= csr_pwdata[pcp_pkg::GAIN_W-1:0];
            pcp_pkg::REG_SPEED_KI:    cfg_ff.speed_ki    <= csr_pwdata[pcp_pkg::GAIN_W-1:0];
            pcp_pkg::REG_SPEED_KD:    cfg_ff.speed_kd    <= csr_pwdata[pcp_pkg::GAIN_W-1:0];
            pcp_pkg::REG_PITCH_UPPER: cfg_ff.pitch_upper <= csr_pwdata[pcp_pkg::LIMIT_W-1:0];
            pcp_pkg::REG_PITCH_LOWER: cfg_ff.pitch_lower <= csr_pwdata[pcp_pkg::LIMIT_W-1:0];
            default:                  cfg_ff             <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         pcp_pkg::REG_ANGLE_KP:    csr_prdata = pcp_pkg::CSR_DATA_W'(cfg_ff.angle_kp);
         pcp_pkg::REG_ANGLE_KI:    csr_prdata = pcp_pkg::CSR_DATA_W'(cfg_ff.angle_ki);
         pcp_pkg::REG_ANGLE_KD:    csr_prdata = pcp_pkg::CSR_DATA_W'(cfg_ff.angle_kd);
         pcp_pkg::REG_SPEED_KP:    csr_prdata = pcp_pkg::CSR_DATA_W'(cfg_ff.speed_kp);
         pcp_pkg::REG_SPEED_KI:    csr_prdata = pcp_pkg::CSR_DATA_W'(cfg_ff.speed_ki);
         pcp_pkg::REG_SPEED_KD:    csr_prdata = pcp_pkg::CSR_DATA_W'(cfg_ff.speed_kd);
         pcp_pkg::REG_PITCH_UPPER: csr_prdata = pcp_pkg::CSR_DATA_W'(cfg_ff.pitch_upper);
         pcp_pkg::REG_PITCH_LOWER: csr_prdata = pcp_pkg::CSR_DATA_W'(cfg_ff.pitch_lower);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

FILE: src/pitch_cascade_pid.sv
// Pitch axis cascaded angle/speed PID: one control tick per accepted item.
// Sequence: ST_ANG_MUL through ST_TQ; rsp_tvalid rises when ST_TQ is left, which waits
// until the output register is free. A new item is accepted only in ST_IDLE, since the single
// 33x25 multiplier serves all nine products of a tick (scale, stick, six gains, /20).
// Reset (synchronous) clears the registers, the reference and all loop state.
module pitch_cascade_pid (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // stick [10:0], roll_angle [35:11], pitch_rate [59:36], zero fill above
   input  logic [pcp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // cmd [1:0]
   input  logic [pcp_pkg::CMD_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // torque [19:0], angle_loop_out [51:20], reference [83:52], zero fill above
   output logic [pcp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pcp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pcp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pcp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
   localparam logic [ST_W-1:0] ST_ANG_MUL = 5'd1;
   localparam logic [ST_W-1:0] ST_ANG     = 5'd2;
   localparam logic [ST_W-1:0] ST_LIMIT   = 5'd3;
   localparam logic [ST_W-1:0] ST_REF     = 5'd4;
   localparam logic [ST_W-1:0] ST_ERR     = 5'd5;
   localparam logic [ST_W-1:0] ST_AP      = 5'd6;
   localparam logic [ST_W-1:0] ST_AI      = 5'd7;
   localparam logic [ST_W-1:0] ST_AD      = 5'd8;
   localparam logic [ST_W-1:0] ST_AOUT    = 5'd9;
   localparam logic [ST_W-1:0] ST_SERR    = 5'd10;
   localparam logic [ST_W-1:0] ST_SP      = 5'd11;
   localparam logic [ST_W-1:0] ST_SI      = 5'd12;
   localparam logic [ST_W-1:0] ST_SD      = 5'd13;
   localparam logic [ST_W-1:0] ST_SUM     = 5'd14;
   localparam logic [ST_W-1:0] ST_DIV     = 5'd15;
   localparam logic [ST_W-1:0] ST_TQ      = 5'd16;

   localparam longint MAX32 = (longint'(1) << 31) - 1;
   localparam longint MIN32 = -(longint'(1) << 31);
   localparam longint MAX48 = (longint'(1) << 47) - 1;
   localparam longint MIN48 = -(longint'(1) << 47);
   localparam longint TQ_LIMIT = 100 * pcp_pkg::ONE_Q;
   localparam longint TQ_MAX   = 5 * pcp_pkg::ONE_Q;
   localparam longint DIV_BIAS = longint'(20) << pcp_pkg::DIV_BIAS_SHIFT;
   localparam longint DIV_OFF  = longint'(1) << pcp_pkg::DIV_BIAS_SHIFT;

   function automatic logic signed [pcp_pkg::WORD_W-1:0] sat32(input longint v);
      if (v > MAX32) begin
         return pcp_pkg::WORD_W'(MAX32);
      end else if (v < MIN32) begin
         return pcp_pkg::WORD_W'(MIN32);
      end
      return v[pcp_pkg::WORD_W-1:0];
   endfunction

   function automatic logic signed [pcp_pkg::SINT_W-1:0] sat48(input longint v);
      if (v > MAX48) begin
         return pcp_pkg::SINT_W'(MAX48);
      end else if (v < MIN48) begin
         return pcp_pkg::SINT_W'(MIN48);
      end
      return v[pcp_pkg::SINT_W-1:0];
   endfunction

   // Round half up, then drop the fraction bits of a gain product.
   function automatic logic signed [pcp_pkg::RND_W-1:0] rnd(
      input logic signed [pcp_pkg::MUL_P_W-1:0] p);
      logic signed [pcp_pkg::MUL_P_W-1:0] t;
      t = p + (pcp_pkg::MUL_P_W'(1) << (pcp_pkg::FRAC_BITS - 1));
      return t[pcp_pkg::MUL_P_W-1:pcp_pkg::FRAC_BITS];
   endfunction

   pcp_pkg::pcp_cfg_type                      cfg;
   pcp_pkg::pcp_mul_req_type                  mreq;
   logic signed [pcp_pkg::MUL_P_W-1:0]        prod_ff;
   logic signed [pcp_pkg::RND_W-1:0]          prod_rnd;

   logic [ST_W-1:0]                           state_ff;
   logic [ST_W-1:0]                           state_in;
   logic                                      req_fire;
   logic                                      out_free;

   logic [pcp_pkg::CMD_W-1:0]                 cmd_ff;
   logic signed [pcp_pkg::STICK_W-1:0]        stick_ff;
   logic signed [pcp_pkg::ROLL_W-1:0]         roll_ff;
   logic signed [pcp_pkg::RATE_W-1:0]         rate_ff;

   logic signed [pcp_pkg::WORD_W-1:0]         ang_ff;
   logic signed [pcp_pkg::WORD_W-1:0]         err_ff;
   logic signed [pcp_pkg::RND_W-1:0]          p_ff;
   logic signed [pcp_pkg::WORD_W-1:0]         aout_ff;
   logic signed [pcp_pkg::SUM_W-1:0]          sum_ff;

   logic signed [pcp_pkg::WORD_W-1:0]         ref_ff;
   logic signed [pcp_pkg::AINT_W-1:0]         aint_ff;
   logic signed [pcp_pkg::WORD_W-1:0]         aprev_ff;
   logic signed [pcp_pkg::SINT_W-1:0]         sint_ff;
   logic signed [pcp_pkg::WORD_W-1:0]         sprev_ff;

   logic                                      rsp_valid_ff;
   logic [pcp_pkg::TORQUE_W-1:0]              rsp_torque_ff;
   logic [pcp_pkg::WORD_W-1:0]                rsp_aout_ff;
   logic [pcp_pkg::WORD_W-1:0]                rsp_ref_ff;

   logic signed [pcp_pkg::WORD_W-1:0]         upper_w;
   logic signed [pcp_pkg::WORD_W-1:0]         lower_w;
   logic signed [pcp_pkg::WORD_W-1:0]         lim_ref;
   logic                                      lim_clear;
   longint                                    aint_sum;
   logic signed [pcp_pkg::AINT_W-1:0]         aint_in;
   logic signed [pcp_pkg::SUM_W-1:0]          div_x;
   longint                                    tq_div;
   logic [pcp_pkg::TORQUE_W-1:0]              torque_in;

   pcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pcp_mul u_mul (
      .clock   (clock),
      .req     (mreq),
      .prod_ff (prod_ff)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{pcp_pkg::RSP_PAD_W{1'b0}}, rsp_ref_ff, rsp_aout_ff, rsp_torque_ff};
   assign prod_rnd   = rnd(prod_ff);

   assign upper_w = pcp_pkg::WORD_W'($signed(cfg.pitch_upper));
   assign lower_w = pcp_pkg::WORD_W'($signed(cfg.pitch_lower));

   // Upper limit is checked first, so crossed limits leave the lower one.
   always_comb begin
      lim_ref   = ref_ff;
      lim_clear = 1'b0;
      if (lim_ref > upper_w) begin
         lim_ref = upper_w;
         if (ang_ff >= upper_w) begin
            lim_clear = 1'b1;
         end
      end
      if (lim_ref < lower_w) begin
         lim_ref = lower_w;
         if (ang_ff <= lower_w) begin
            lim_clear = 1'b1;
         end
      end
   end

   always_comb begin
      aint_sum = longint'(aint_ff) + longint'(prod_rnd);
      if (aint_sum >= pcp_pkg::ONE_Q) begin
         aint_in = pcp_pkg::AINT_W'(pcp_pkg::ONE_Q);
      end else if (aint_sum <= -pcp_pkg::ONE_Q) begin
         aint_in = pcp_pkg::AINT_W'(-pcp_pkg::ONE_Q);
      end else begin
         aint_in = aint_sum[pcp_pkg::AINT_W-1:0];
      end
   end

   // The divide by 20 runs on a biased, always positive dividend: the bias
   // makes truncation equal to floor, and the low two bits are shifted out
   // before the multiply by the reciprocal of five.
   assign div_x = sum_ff + pcp_pkg::SUM_W'(10) + pcp_pkg::SUM_W'(DIV_BIAS);

   always_comb begin
      tq_div = longint'(prod_ff >>> pcp_pkg::DIV_SHIFT) - DIV_OFF;
      if (longint'(sum_ff) >= TQ_LIMIT) begin
         torque_in = pcp_pkg::TORQUE_W'(TQ_MAX);
      end else if (longint'(sum_ff) <= -TQ_LIMIT) begin
         torque_in = pcp_pkg::TORQUE_W'(-TQ_MAX);
      end else begin
         torque_in = tq_div[pcp_pkg::TORQUE_W-1:0];
      end
   end

   always_comb begin
      mreq.en = 1'b0;
      mreq.a  = '0;
      mreq.b  = '0;
      unique case (state_ff)
         ST_ANG_MUL: begin
            mreq.en = 1'b1;
            mreq.a  = pcp_pkg::MUL_A_W'(roll_ff);
            mreq.b  = pcp_pkg::MUL_B_W'(pcp_pkg::SCALE_K);
         end
         ST_LIMIT: begin
            mreq.en = 1'b1;
            mreq.a  = pcp_pkg::MUL_A_W'(stick_ff);
            mreq.b  = pcp_pkg::MUL_B_W'(pcp_pkg::STICK_K);
         end
         ST_AP: begin
            mreq.en = 1'b1;
            mreq.a  = pcp_pkg::MUL_A_W'(err_ff);
            mreq.b  = pcp_pkg::MUL_B_W'(cfg.angle_kp);
         end
         ST_AI: begin
            mreq.en = 1'b1;
            mreq.a  = pcp_pkg::MUL_A_W'(err_ff);
            mreq.b  = pcp_pkg::MUL_B_W'(cfg.angle_ki);
         end
         ST_AD: begin
            mreq.en = 1'b1;
            mreq.a  = pcp_pkg::MUL_A_W'(err_ff) - pcp_pkg::MUL_A_W'(aprev_ff);
            mreq.b  = pcp_pkg::MUL_B_W'(cfg.angle_kd);
         end
         ST_SP: begin
            mreq.en = 1'b1;
            mreq.a  = pcp_pkg::MUL_A_W'(err_ff);
            mreq.b  = pcp_pkg::MUL_B_W'(cfg.speed_kp);
         end
         ST_SI: begin
            mreq.en = 1'b1;
            mreq.a  = pcp_pkg::MUL_A_W'(err_ff);
            mreq.b  = pcp_pkg::MUL_B_W'(cfg.speed_ki);
         end
         ST_SD: begin
            mreq.en = 1'b1;
            mreq.a  = pcp_pkg::MUL_A_W'(err_ff) - pcp_pkg::MUL_A_W'(sprev_ff);
            mreq.b  = pcp_pkg::MUL_B_W'(cfg.speed_kd);
         end
         ST_DIV: begin
            mreq.en = 1'b1;
            mreq.a  = div_x[pcp_pkg::MUL_A_W+1:2];
            mreq.b  = pcp_pkg::MUL_B_W'(pcp_pkg::DIV5_K);
         end
         default: begin
            mreq.en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_fire) state_in = ST_ANG_MUL;
         ST_ANG_MUL: state_in = ST_ANG;
         ST_ANG:     state_in = ST_LIMIT;
         ST_LIMIT:   state_in = ST_REF;
         ST_REF:     state_in = ST_ERR;
         ST_ERR:     state_in = ST_AP;
         ST_AP:      state_in = ST_AI;
         ST_AI:      state_in = ST_AD;
         ST_AD:      state_in = ST_AOUT;
         ST_AOUT:    state_in = ST_SERR;
         ST_SERR:    state_in = ST_SP;
         ST_SP:      state_in = ST_SI;
         ST_SI:      state_in = ST_SD;
         ST_SD:      state_in = ST_SUM;
         ST_SUM:     state_in = ST_DIV;
         ST_DIV:     state_in = ST_TQ;
         ST_TQ:      if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer, loop state and output handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ref_ff       <= '0;
         aint_ff      <= '0;
         aprev_ff     <= '0;
         sint_ff      <= '0;
         sprev_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_TQ && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LIMIT: begin
               ref_ff <= lim_ref;
               if (lim_clear) begin
                  sint_ff <= '0;
               end
            end
            ST_REF: begin
               if (cmd_ff == pcp_pkg::CMD_REMOTE) begin
                  ref_ff <= sat32(longint'(ref_ff) + longint'(prod_ff));
               end else begin
                  ref_ff <= ang_ff;
               end
            end
            ST_AD: begin
               aint_ff  <= aint_in;
               aprev_ff <= err_ff;
            end
            ST_SD: begin
               sint_ff  <= sat48(longint'(sint_ff) + longint'(prod_rnd));
               sprev_ff <= err_ff;
            end
            default: begin
               ref_ff <= ref_ff;
            end
         endcase
      end
   end

   // Working registers of a tick.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_tuser;
         stick_ff <= req_tdata[0 +: pcp_pkg::STICK_W];
         roll_ff  <= req_tdata[pcp_pkg::ROLL_LSB +: pcp_pkg::ROLL_W];
         rate_ff  <= req_tdata[pcp_pkg::RATE_LSB +: pcp_pkg::RATE_W];
      end
      unique case (state_ff)
         ST_ANG:  ang_ff  <= sat32(longint'(prod_rnd));
         ST_ERR:  err_ff  <= sat32(longint'(ref_ff) - longint'(ang_ff));
         ST_AI:   p_ff    <= prod_rnd;
         ST_AOUT: aout_ff <= sat32(longint'(p_ff) + longint'(aint_ff) + longint'(prod_rnd));
         ST_SERR: err_ff  <= sat32(longint'(aout_ff) - longint'(rate_ff));
         ST_SI:   p_ff    <= prod_rnd;
         ST_SUM: begin
            sum_ff <= pcp_pkg::SUM_W'(longint'(p_ff) + longint'(sint_ff) + longint'(prod_rnd));
         end
         ST_TQ: begin
            if (out_free) begin
               rsp_torque_ff <= torque_in;
               rsp_aout_ff   <= aout_ff;
               rsp_ref_ff    <= ref_ff;
            end
         end
         default: begin
            p_ff <= p_ff;
         end
      endcase
   end

endmodule

FILE: test/pitch_pid_checker.sv
// Checker for the pitch cascade PID: predicts every tick and compares each result field.
`timescale 1ns / 1ps

module pitch_pid_checker
   import pcp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]       req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int                     failures,
   output int                     outstanding
);

   // First declared member sits in the top bits, so torque lands in the lowest bits.
   typedef struct packed {
      logic [WORD_W-1:0]   reference;
      logic [WORD_W-1:0]   angle_out;
      logic [TORQUE_W-1:0] torque;
   } pid_out_t;

   pcp_cfg_type cfg;
   longint      pitch_ref;
   longint      angle_int;
   longint      angle_prev;
   longint      speed_int;
   longint      speed_prev;
   pid_out_t    tick_results[$];
   pid_out_t    want;
   pid_out_t    got;
   int          results_seen;

   function automatic longint clip(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Product with an unsigned Q.F gain, rounded half up back to Q.F.
   function automatic longint gain_mul(input longint v, input logic [GAIN_W-1:0] g);
      return (v * longint'(g) + (ONE_Q >>> 1)) >>> FRAC_BITS;
   endfunction

   // One control tick: updates the loop state and returns the expected result.
   function automatic pid_out_t step_pid(input logic [CMD_W-1:0] cmd,
                                         input logic [REQ_TDATA_W-1:0] data);
      longint   stick, roll, rate, upper, lower, ang, held;
      longint   err, p, integ, d, aout, serr, sum, trq;
      pid_out_t r;
      stick = longint'($signed(data[STICK_W-1:0]));
      roll  = longint'($signed(data[ROLL_LSB +: ROLL_W]));
      rate  = longint'($signed(data[RATE_LSB +: RATE_W]));
      upper = longint'($signed(cfg.pitch_upper));
      lower = longint'($signed(cfg.pitch_lower));

      ang = clip((roll * SCALE_K + (ONE_Q >>> 1)) >>> FRAC_BITS, WORD_W);

      // Upper limit is tested first, so crossed limits leave the lower one.
      held = pitch_ref;
      if (held > upper) begin
         held = upper;
         if (ang >= upper) speed_int = 0;
      end
      if (held < lower) begin
         held = lower;
         if (ang <= lower) speed_int = 0;
      end
      if (cmd == CMD_REMOTE) held = clip(held + stick * STICK_K, WORD_W);
      else held = ang;
      pitch_ref = held;

      err   = clip(held - ang, WORD_W);
      p     = gain_mul(err, cfg.angle_kp);
      integ = angle_int + gain_mul(err, cfg.angle_ki);
      if (integ >= ONE_Q) integ = ONE_Q;
      else if (integ <= -ONE_Q) integ = -ONE_Q;
      angle_int  = integ;
      d          = gain_mul(err - angle_prev, cfg.angle_kd);
      angle_prev = err;
      aout       = clip(p + integ + d, WORD_W);

      serr       = clip(aout - rate, WORD_W);
      p          = gain_mul(serr, cfg.speed_kp);
      speed_int  = clip(speed_int + gain_mul(serr, cfg.speed_ki), SINT_W);
      d          = gain_mul(serr - speed_prev, cfg.speed_kd);
      speed_prev = serr;
      sum        = p + speed_int + d;

      if (sum >= 100 * ONE_Q) trq = 5 * ONE_Q;
      else if (sum <= -100 * ONE_Q) trq = -5 * ONE_Q;
      else trq = (sum + 10 + 20 * (128 * ONE_Q)) / 20 - 128 * ONE_Q;

      r.torque    = TORQUE_W'(trq);
      r.angle_out = WORD_W'(aout);
      r.reference = WORD_W'(held);
      return r;
   endfunction

   task automatic report_diff(input string what, input logic [WORD_W-1:0] exp_v,
                              input logic [WORD_W-1:0] act_v);
      failures++;
      if (failures <= 10)
         $display("result %0d: %s expected %h, got %h", results_seen, what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg        = '0;
         pitch_ref  = 0;
         angle_int  = 0;
         angle_prev = 0;
         speed_int  = 0;
         speed_prev = 0;
         tick_results.delete();
         outstanding <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_ANGLE_KP:    cfg.angle_kp    = csr_pwdata[GAIN_W-1:0];
               REG_ANGLE_KI:    cfg.angle_ki    = csr_pwdata[GAIN_W-1:0];
               REG_ANGLE_KD:    cfg.angle_kd    = csr_pwdata[GAIN_W-1:0];
               REG_SPEED_KP:    cfg.speed_kp    = csr_pwdata[GAIN_W-1:0];
               REG_SPEED_KI:    cfg.speed_ki    = csr_pwdata[GAIN_W-1:0];
               REG_SPEED_KD:    cfg.speed_kd    = csr_pwdata[GAIN_W-1:0];
               REG_PITCH_UPPER: cfg.pitch_upper = csr_pwdata[LIMIT_W-1:0];
               REG_PITCH_LOWER: cfg.pitch_lower = csr_pwdata[LIMIT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (tick_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("result %0d: no tick pending, got %h", results_seen, rsp_tdata);
            end else begin
               want = tick_results.pop_front();
               got  = rsp_tdata[RSP_BITS-1:0];
               if (got.torque !== want.torque)
                  report_diff("torque", want.torque, got.torque);
               if (got.angle_out !== want.angle_out)
                  report_diff("angle_loop_out", want.angle_out, got.angle_out);
               if (got.reference !== want.reference)
                  report_diff("reference", want.reference, got.reference);
               if (rsp_tdata[RSP_TDATA_W-1:RSP_BITS] !== '0)
                  report_diff("zero fill", '0, rsp_tdata[RSP_TDATA_W-1:RSP_BITS]);
            end
         end

         if (req_tvalid && req_tready)
            tick_results.push_back(step_pid(req_tuser, req_tdata));

         outstanding <= tick_results.size();
      end
   end

endmodule

FILE: test/testbench.sv
// Top of the pitch cascade PID testbench: clock, reset, register setup and tick stimulus.
`timescale 1ns / 1ps

module testbench;
   import pcp_pkg::*;

   localparam logic [CMD_W-1:0] CMD_STOP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_VISION = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TRACK  = 2'd3;

   localparam int EP_DRIVE  = 0;
   localparam int EP_TRACK  = 1;
   localparam int EP_NOISE  = 2;
   localparam int EP_WINDUP = 3;

   localparam int     CYCLE_LIMIT = 1_000_000;
   localparam longint ROLL_MAX    = (longint'(1) << (ROLL_W - 1)) - 1;
   localparam longint ROLL_MIN    = -(longint'(1) << (ROLL_W - 1));
   localparam longint RATE_MAX    = (longint'(1) << (RATE_W - 1)) - 1;
   localparam longint RATE_MIN    = -(longint'(1) << (RATE_W - 1));
   localparam longint LIMIT_MAX   = (longint'(1) << (LIMIT_W - 1)) - 1;
   localparam longint LIMIT_MIN   = -(longint'(1) << (LIMIT_W - 1));

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [CMD_W-1:0]       req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int     failures;
   int     outstanding;
   int     cycle_count = 0;
   int     rsp_left    = 0;
   int     rsp_stall;
   bit     steady      = 1'b0;
   longint cur_upper   = 0;
   longint cur_lower   = 0;

   always #2 clock = ~clock;

   pitch_cascade_pid dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pitch_pid_checker watch (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      if (r < 70) return GAIN_W'($urandom_range(0, 2 * ONE_Q));
      if (r < 85) return GAIN_W'($urandom_range(0, ONE_Q / 8));
      return GAIN_W'($urandom);
   endfunction

   function automatic longint rand_limit();
      longint mag;
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? LIMIT_MAX : LIMIT_MIN;
      mag = longint'($urandom_range(0, 1 << 23));
      return $urandom_range(0, 1) ? mag : -mag;
   endfunction

   // A roll angle whose scaled value lands close to the given limit.
   function automatic longint roll_near(input longint lim);
      longint t;
      t = (lim <<< FRAC_BITS) / SCALE_K + longint'($urandom_range(0, 4000)) - 2000;
      if (t > ROLL_MAX) t = ROLL_MAX;
      if (t < ROLL_MIN) t = ROLL_MIN;
      return t;
   endfunction

   function automatic longint rand_rate();
      if ($urandom_range(0, 4) != 0)
         return longint'($urandom_range(0, 1 << 17)) - (longint'(1) << 16);
      return longint'($signed(RATE_W'($urandom)));
   endfunction

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Unused upper bits of each write carry junk; the block keeps only the register width.
   task automatic apply_setting(input logic [GAIN_W-1:0] akp, aki, akd, skp, ski, skd,
                                input longint up, lo);
      write_reg(REG_ANGLE_KP, {8'($urandom), akp});
      write_reg(REG_ANGLE_KI, {8'($urandom), aki});
      write_reg(REG_ANGLE_KD, {8'($urandom), akd});
      write_reg(REG_SPEED_KP, {8'($urandom), skp});
      write_reg(REG_SPEED_KI, {8'($urandom), ski});
      write_reg(REG_SPEED_KD, {8'($urandom), skd});
      write_reg(REG_PITCH_UPPER, {3'($urandom), LIMIT_W'(up)});
      write_reg(REG_PITCH_LOWER, {3'($urandom), LIMIT_W'(lo)});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cur_upper = longint'($signed(LIMIT_W'(up)));
      cur_lower = longint'($signed(LIMIT_W'(lo)));
   endtask

   // Valid is lowered only when a gap follows, so it never toggles within one step.
   task automatic send_tick(input logic [CMD_W-1:0] cmd, input longint stick, roll, rate);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_W - RATE_LSB - RATE_W){1'b0}},
                     RATE_W'(rate), ROLL_W'(roll), STICK_W'(stick)};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic run_episode(input int kind, input int count);
      longint lim, roll, stick, fixed_roll;
      bit     up_dir;
      up_dir     = $urandom_range(0, 1);
      lim        = up_dir ? cur_upper : cur_lower;
      roll       = longint'($urandom_range(0, 1 << 20)) - (longint'(1) << 19);
      fixed_roll = longint'($urandom_range(1 << 20, (1 << 24) - 1));
      for (int n = 0; n < count; n++) begin
         case (kind)
            EP_DRIVE: begin
               stick = up_dir ? longint'($urandom_range(0, 1023))
                              : -longint'($urandom_range(0, 1024));
               // An occasional tracking tick drops the reference onto the angle.
               if ($urandom_range(0, 9) == 0)
                  send_tick(CMD_W'($urandom_range(1, 3)), stick, roll_near(lim), rand_rate());
               else
                  send_tick(CMD_REMOTE, stick, roll_near(lim), rand_rate());
            end
            EP_TRACK: begin
               roll = roll + longint'($urandom_range(0, 1 << 15)) - (longint'(1) << 14);
               if (roll > ROLL_MAX) roll = ROLL_MAX;
               if (roll < ROLL_MIN) roll = ROLL_MIN;
               if ($urandom_range(0, 7) == 0)
                  send_tick(CMD_REMOTE, longint'($urandom_range(0, 64)) - 32, roll, rand_rate());
               else
                  send_tick(CMD_W'($urandom_range(1, 3)), longint'($urandom), roll,
                            rand_rate());
            end
            EP_WINDUP: begin
               // Reference pinned at one limit, angle far on the other side.
               stick = longint'($urandom_range(512, 1023));
               send_tick(CMD_REMOTE, up_dir ? stick : -stick,
                         up_dir ? -fixed_roll : fixed_roll, rand_rate());
            end
            default:
               send_tick(CMD_W'($urandom), longint'($urandom), longint'($urandom),
                         longint'($urandom));
         endcase
      end
   endtask

   task automatic run_phase(input int count);
      int left, len, r;
      left = count;
      while (left > 0) begin
         len = $urandom_range(5, 40);
         if (len > left) len = left;
         r = $urandom_range(0, 99);
         if (r < 40) run_episode(EP_DRIVE, len);
         else if (r < 65) run_episode(EP_TRACK, len);
         else if (r < 80) run_episode(EP_NOISE, len);
         else run_episode(EP_WINDUP, len);
         left -= len;
      end
   endtask

   // Result side: ready runs and stalls of random length, none while steady.
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_tready <= 1'b1;
      end else if (rsp_left > 0) begin
         rsp_left <= rsp_left - 1;
      end else if (!rsp_tready) begin
         rsp_tready <= 1'b1;
         rsp_left   <= $urandom_range(0, 15);
      end else begin
         rsp_stall = pick_gap();
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_left   <= rsp_stall - 1;
         end else begin
            rsp_left <= $urandom_range(0, 15);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      apply_setting(GAIN_W'(ONE_Q), GAIN_W'(ONE_Q / 4), GAIN_W'(ONE_Q / 8),
                    GAIN_W'(ONE_Q / 2), GAIN_W'(ONE_Q / 16), GAIN_W'(ONE_Q / 32),
                    longint'(1) << 22, -(longint'(1) << 22));
      send_tick(CMD_REMOTE, 0, 0, 0);
      send_tick(CMD_REMOTE, 1023, 0, 0);
      send_tick(CMD_REMOTE, -1024, ROLL_MAX, RATE_MAX);
      // Reference jumps onto a scaled angle far above the upper limit.
      send_tick(CMD_STOP, 0, ROLL_MAX, RATE_MIN);
      // Clamped at the upper limit with the angle beyond it: speed integral clears.
      send_tick(CMD_REMOTE, 1023, ROLL_MAX, 0);
      send_tick(CMD_VISION, 0, ROLL_MIN, RATE_MAX);
      send_tick(CMD_REMOTE, -1024, ROLL_MIN, RATE_MIN);
      send_tick(CMD_TRACK, 0, 12345, -1);
      send_tick(CMD_REMOTE, 1023, ROLL_MIN, RATE_MAX);
      send_tick(CMD_REMOTE, 1023, ROLL_MIN, RATE_MAX);
      send_tick(CMD_REMOTE, -1, -1, -1);
      send_tick(CMD_STOP, -1024, 1, 1);
      drain();

      // Crossed limits: the reference must settle on the lower one.
      apply_setting(GAIN_W'(ONE_Q * 2), GAIN_W'(ONE_Q), '0, GAIN_W'(ONE_Q), GAIN_W'(ONE_Q), '0,
                    -(longint'(1) << 20), longint'(1) << 20);
      send_tick(CMD_TRACK, 0, 0, 0);
      send_tick(CMD_REMOTE, 0, 0, 0);
      send_tick(CMD_REMOTE, 1023, roll_near(cur_lower), 0);
      send_tick(CMD_VISION, 0, ROLL_MAX, 0);
      send_tick(CMD_REMOTE, -1024, roll_near(cur_upper), RATE_MIN);
      send_tick(CMD_REMOTE, 0, 0, 0);
      drain();

      // Largest gains and widest limits: saturation of every loop term.
      apply_setting('1, '1, '1, '1, '1, '1, LIMIT_MAX, LIMIT_MIN);
      run_episode(EP_WINDUP, 280);
      run_episode(EP_DRIVE, 20);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         steady = (ph % 3 == 1);
         if (ph == 0)
            apply_setting('0, '0, '0, '0, '0, '0, rand_limit(), rand_limit());
         else
            apply_setting(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                          rand_gain(), rand_limit(), rand_limit());
         // Most phases keep the limits in order.
         if (cur_upper < cur_lower && $urandom_range(0, 5) != 0) begin
            @(posedge clock);
            apply_setting(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                          rand_gain(), cur_lower, cur_upper);
         end
         run_phase(130);
         drain();
      end

      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
src/pcp_pkg.sv
src/pcp_mul.sv
src/pcp_csr.sv
src/pitch_cascade_pid.sv
test/pitch_pid_checker.sv
test/testbench.sv
